/* sv/lrukv_pkg.sv */
// Package for the LRU key-value cache: widths, codes, controller state,
// and the command and status groups between controller and datapath.
// No dependencies.
package lrukv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic [CAP_W-1:0]        CAP_RESET  = 5'd16;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [VAL_W-1:0] PUT_VALUE  = 32'sd0;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic match;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/lrukv_if.sv */
// Channel interfaces of the LRU key-value cache: request, response, and
// capacity write. Depends on lrukv_pkg.
interface lrukv_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [lrukv_pkg::KEY_W-1:0]   lookup_key;
  logic signed [lrukv_pkg::VAL_W-1:0]   store_value;
  modport source (output valid, mode, lookup_key, store_value, input ready);
  modport sink   (input valid, mode, lookup_key, store_value, output ready);
endinterface

interface lrukv_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic signed [lrukv_pkg::VAL_W-1:0]   read_value;
  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

interface lrukv_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lrukv_pkg::CAP_W-1:0]          capacity;
  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

/* sv/lrukv_ctrl.sv */
// Controller of the LRU key-value cache: sequences accept, match and commit.
// Depends on lrukv_pkg.
module lrukv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrukv_pkg::dp_status_t status,
  output lrukv_pkg::ctrl_cmd_t  cmd
);

  lrukv_pkg::ctrl_state_t state_r;
  lrukv_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrukv_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrukv_pkg::S_IDLE: begin
        if (status.in_valid) state_nxt = lrukv_pkg::S_MATCH;
      end
      lrukv_pkg::S_MATCH: begin
        state_nxt = lrukv_pkg::S_COMMIT;
      end
      lrukv_pkg::S_COMMIT: begin
        if (status.out_free) begin
          state_nxt = status.in_valid ? lrukv_pkg::S_MATCH : lrukv_pkg::S_IDLE;
        end
      end
      default: state_nxt = lrukv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      lrukv_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      lrukv_pkg::S_MATCH: begin
        cmd.match = 1'b1;
      end
      lrukv_pkg::S_COMMIT: begin
        cmd.commit   = status.out_free;
        cmd.in_ready = status.out_free;
      end
      default: cmd = '0;
    endcase
    cmd.capture = cmd.in_ready && status.in_valid;
  end

  a_capture_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (state_r == lrukv_pkg::S_IDLE || state_r == lrukv_pkg::S_COMMIT))
    else $error("beat captured while busy");

  a_match_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match |=> state_r == lrukv_pkg::S_COMMIT)
    else $error("match not followed by commit");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.out_free)
    else $error("commit with output full");

endmodule

/* sv/lrukv_dp.sv */
// Datapath of the LRU key-value cache: entry cells with key compare and
// recency ranks, value memory, capacity register, output register.
// Depends on lrukv_pkg and lrukv_if.
module lrukv_dp #(
  parameter int ENTRIES = lrukv_pkg::ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lrukv_in_if.sink              in_if,
  lrukv_out_if.source           out_if,
  lrukv_cfg_if.sink             cfg_if,
  input  lrukv_pkg::ctrl_cmd_t  cmd,
  output lrukv_pkg::dp_status_t status
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int OW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (OW > lrukv_pkg::CAP_W) ? OW : lrukv_pkg::CAP_W;
  localparam logic [CMPW-1:0] ENT_C = CMPW'(ENTRIES);

  logic                          mode_r;
  logic [lrukv_pkg::KEY_W-1:0]   key_r;
  logic [lrukv_pkg::VAL_W-1:0]   val_r;
  logic [lrukv_pkg::CAP_W-1:0]   cap_r;

  logic [ENTRIES-1:0]            valid_r, valid_nxt;
  logic [IW-1:0]                 rank_r   [ENTRIES];
  logic [IW-1:0]                 rank_nxt [ENTRIES];
  logic [lrukv_pkg::KEY_W-1:0]   entry_key_r [ENTRIES];
  logic [lrukv_pkg::VAL_W-1:0]   value_mem   [ENTRIES];
  logic [OW-1:0]                 occ_r, occ_nxt;

  logic [ENTRIES-1:0]            hit_vec, victim_vec, free_vec;
  logic                          hit_any, evict;
  logic [IW-1:0]                 hit_idx, hit_rank, ins_idx, occ_m1;
  logic [CMPW-1:0]               effcap, cap_ext, occ_ext;

  logic                          found_r;
  logic [ENTRIES-1:0]            hit_vec_r, victim_vec_r;
  logic [IW-1:0]                 hit_idx_r, hit_rank_r, ins_idx_r;
  logic                          evict_r;
  logic [lrukv_pkg::VAL_W-1:0]   rd_value_r;

  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;

  logic                          out_valid_r;
  logic                          out_found_r;
  logic [lrukv_pkg::VAL_W-1:0]   out_value_r;
  logic [lrukv_pkg::VAL_W-1:0]   out_value_nxt;

  assign in_if.ready     = cmd.in_ready;
  assign cfg_if.ready    = 1'b1;
  assign status.in_valid = in_if.valid;
  assign status.out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_if.mode;
      key_r  <= in_if.lookup_key;
      val_r  <= in_if.store_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lrukv_pkg::CAP_RESET;
    end else if (cfg_if.valid) begin
      cap_r <= cfg_if.capacity;
    end
  end

  // match stage
  always_comb begin
    cap_ext = CMPW'(cap_r);
    occ_ext = CMPW'(occ_r);
    if (cap_r == '0) begin
      effcap = CMPW'(1);
    end else if (cap_ext > ENT_C) begin
      effcap = ENT_C;
    end else begin
      effcap = cap_ext;
    end
    occ_m1   = IW'(occ_r - OW'(1));
    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && (entry_key_r[i] == key_r);
      victim_vec[i] = valid_r[i] && (rank_r[i] == occ_m1);
      if (hit_vec[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
    end
    hit_any  = |hit_vec;
    evict    = (mode_r == lrukv_pkg::MODE_PUT) && !hit_any && (occ_ext >= effcap);
    free_vec = ~(valid_r & ~(evict ? victim_vec : '0));
    ins_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) ins_idx = IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      found_r      <= hit_any;
      hit_vec_r    <= hit_vec;
      hit_idx_r    <= hit_idx;
      hit_rank_r   <= hit_rank;
      evict_r      <= evict;
      victim_vec_r <= victim_vec;
      ins_idx_r    <= ins_idx;
    end
  end

  // commit stage
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (cmd.commit) begin
      if (found_r) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec_r[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
      end else if (mode_r == lrukv_pkg::MODE_PUT) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (ins_idx_r == IW'(i)) begin
            valid_nxt[i] = 1'b1;
            rank_nxt[i]  = '0;
          end else begin
            valid_nxt[i] = valid_r[i] && !(evict_r && victim_vec_r[i]);
            if (valid_nxt[i]) rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        occ_nxt = occ_r + OW'(1) - OW'(evict_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.commit && (mode_r == lrukv_pkg::MODE_PUT) && !found_r &&
          (ins_idx_r == IW'(i))) begin
        entry_key_r[i] <= key_r;
      end
    end
  end

  assign mem_we    = cmd.commit && (mode_r == lrukv_pkg::MODE_PUT);
  assign mem_waddr = found_r ? hit_idx_r : ins_idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[mem_waddr] <= val_r;
    end
    if (cmd.match) begin
      rd_value_r <= value_mem[hit_idx];
    end
  end

  // output register
  always_comb begin
    if (mode_r == lrukv_pkg::MODE_PUT) begin
      out_value_nxt = lrukv_pkg::PUT_VALUE;
    end else if (found_r) begin
      out_value_nxt = rd_value_r;
    end else begin
      out_value_nxt = lrukv_pkg::MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_found_r <= found_r;
      out_value_r <= out_value_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.found      = out_found_r;
  assign out_if.read_value = out_value_r;

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy out of step with valid entries");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(occ_r) <= ENT_C)
    else $error("occupancy above entry count");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0(hit_vec_r))
    else $error("key held in more than one entry");

  a_insert_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (mode_r == lrukv_pkg::MODE_PUT) && !found_r)
      |=> valid_r[$past(ins_idx_r)] && (rank_r[$past(ins_idx_r)] == '0))
    else $error("insert did not land as most recent");

endmodule

/* sv/lru_key_value_cache_unit.sv */
// Top level of the LRU key-value cache: joins controller and datapath.
// Depends on lrukv_pkg, lrukv_if, lrukv_ctrl and lrukv_dp.
//
// Fully associative key-value store with least-recently-used replacement.
// A request beat is accepted, its key is compared against every entry cell
// in the next cycle, and in the commit state that follows, once the output
// register is free, the recency ranks, the entry cells and the value memory
// are updated and the response is loaded into the output register. A new
// request is taken in the same cycle as the commit, so a request can be
// accepted while the previous one is still being committed. A held response
// stalls the commit until taken. Capacity is to be written on the cfg
// channel while the block is idle; the block itself does not enforce this.
// Zero acts as one and values above ENTRIES act as ENTRIES. The store is
// empty after reset, with no clearing pass.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lrukv_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lrukv_in_if.sink    in_if,
  lrukv_out_if.source out_if,
  lrukv_cfg_if.sink   cfg_if
);

  lrukv_pkg::ctrl_cmd_t  cmd;
  lrukv_pkg::dp_status_t status;

  lrukv_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  lrukv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd    (cmd),
    .status (status)
  );

endmodule

/* tb/tb_lru_key_value_cache_unit.sv */
`timescale 1ns / 100ps
// Testbench for lru_key_value_cache_unit: a directed table, then random phases over
// several capacity settings, each response checked against the table's expected
// value or an in-bench LRU store. Depends on lrukv_pkg and the lrukv_if channels.
module tb_lru_key_value_cache_unit;

  localparam int ENTRIES    = lrukv_pkg::ENTRIES_DEF;
  localparam int KEY_W      = lrukv_pkg::KEY_W;
  localparam int VAL_W      = lrukv_pkg::VAL_W;
  localparam int CAP_W      = lrukv_pkg::CAP_W;
  localparam int DIRECTED_N = 22;
  localparam int PHASE_N    = 11;
  localparam int PHASE_LEN  = 50;
  localparam int LONG_HOLD  = 80;
  localparam int IDLE_LIMIT = 1000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
  } cache_result_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] data;
    logic             typed;
    logic             exp_found;
    logic [VAL_W-1:0] exp_value;
  } stim_row_t;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0,
      lrukv_pkg::MISS_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0,
      lrukv_pkg::MISS_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0,
      lrukv_pkg::PUT_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0,
      lrukv_pkg::PUT_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0,
      lrukv_pkg::PUT_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      lrukv_pkg::PUT_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0,
      lrukv_pkg::MISS_VALUE},
    '{ROW_CFG, lrukv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0,
      lrukv_pkg::PUT_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h0000_0002, 32'h0000_0003, 1'b1, 1'b1,
      lrukv_pkg::PUT_VALUE},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h0000_0002, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0003},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_CFG, lrukv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, lrukv_pkg::MODE_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_REQ, lrukv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  int phase_caps [PHASE_N] = '{1, 16, 2, 0, 31, 5, -1, 8, 3, 20, -1};

  logic clk = 1'b0;
  logic rst_n;

  lrukv_in_if  in_ch ();
  lrukv_out_if out_ch ();
  lrukv_cfg_if cfg_ch ();

  lru_key_value_cache_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  always #1 clk = ~clk;

  logic             ent_valid [ENTRIES];
  logic [KEY_W-1:0] ent_key   [ENTRIES];
  logic [VAL_W-1:0] ent_val   [ENTRIES];
  int               ent_rank  [ENTRIES];
  int               occ;
  logic [CAP_W-1:0] cap_reg;

  cache_result_t    response_q [$];
  logic [KEY_W-1:0] key_pool [32];
  int               pool_n;
  int               mismatches  = 0;
  int               burst_left  = 0;
  int               gap_max     = 0;
  int               hold_asks   = 0;
  int               hold_served = 0;
  int               hold_left   = 0;
  int               pat_pos     = 0;
  int               idle_cycles = 0;
  logic [15:0]      stall_pat   = '1;

  function automatic void promote_entry(int s);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_rank[i] < ent_rank[s]) ent_rank[i]++;
    ent_rank[s] = 0;
  endfunction

  function automatic cache_result_t lru_access(logic mode, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] data);
    cache_result_t r;
    int i, hit, victim, slot, lim;
    hit = -1;
    for (i = 0; i < ENTRIES; i++)
      if (hit < 0 && ent_valid[i] && ent_key[i] == key) hit = i;
    r.found = (hit >= 0);
    if (mode == lrukv_pkg::MODE_GET) begin
      r.read_value = lrukv_pkg::MISS_VALUE;
      if (hit >= 0) begin
        r.read_value = ent_val[hit];
        promote_entry(hit);
      end
      return r;
    end
    r.read_value = lrukv_pkg::PUT_VALUE;
    if (hit >= 0) begin
      ent_val[hit] = data;
      promote_entry(hit);
      return r;
    end
    lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
    if (occ >= lim) begin
      victim = -1;
      for (i = 0; i < ENTRIES; i++)
        if (ent_valid[i] && (victim < 0 || ent_rank[i] > ent_rank[victim])) victim = i;
      if (victim >= 0) begin
        ent_valid[victim] = 1'b0;
        occ--;
      end
    end
    slot = -1;
    for (i = 0; i < ENTRIES; i++)
      if (slot < 0 && !ent_valid[i]) slot = i;
    if (slot >= 0) begin
      for (i = 0; i < ENTRIES; i++)
        if (ent_valid[i]) ent_rank[i]++;
      ent_valid[slot] = 1'b1;
      ent_key[slot]   = key;
      ent_val[slot]   = data;
      ent_rank[slot]  = 0;
      occ++;
    end
    return r;
  endfunction

  task automatic send_req(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data,
                          logic typed, cache_result_t typed_res);
    int gap;
    cache_result_t res;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.lookup_key  <= key;
    in_ch.store_value <= data;
    do @(posedge clk); while (!in_ch.ready);
    res = lru_access(mode, key, data);
    response_q.push_back(typed ? typed_res : res);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    in_ch.valid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg = cap;
  endtask

  always @(posedge clk) begin : response_check
    cache_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (response_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: found %0b value %h", out_ch.found, out_ch.read_value);
      end else begin
        want = response_q.pop_front();
        if (out_ch.found !== want.found || out_ch.read_value !== want.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: found exp %0b got %0b, value exp %h got %h",
                     want.found, out_ch.found, want.read_value, out_ch.read_value);
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_asks) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      if (pat_pos == 0) stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      out_ch.ready <= stall_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i, p, n, cap, eff;
    logic [KEY_W-1:0] key;
    cache_result_t typed_res;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= lrukv_pkg::MODE_GET;
    in_ch.lookup_key   <= '0;
    in_ch.store_value  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.capacity    <= lrukv_pkg::CAP_RESET;
    for (i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_val[i]   = '0;
      ent_rank[i]  = 0;
    end
    occ     = 0;
    cap_reg = lrukv_pkg::CAP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    gap_max = 2;
    for (i = 0; i < DIRECTED_N; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_capacity(directed_rows[i].data[CAP_W-1:0]);
      end else begin
        typed_res.found      = directed_rows[i].exp_found;
        typed_res.read_value = directed_rows[i].exp_value;
        send_req(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].data,
                 directed_rows[i].typed, typed_res);
      end
    end

    for (p = 0; p < PHASE_N; p++) begin
      cap = (phase_caps[p] < 0) ? $urandom_range(0, 31) : phase_caps[p];
      write_capacity(cap[CAP_W-1:0]);
      eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
      gap_max = $urandom_range(0, 4);
      // stall the response side long enough to back up the request side
      if (p == 2) hold_asks++;
      pool_n = eff + $urandom_range(1, 6);
      for (n = 0; n < pool_n; n++) key_pool[n] = $urandom;
      case ($urandom_range(0, 4))
        0: key_pool[0] = 32'h0000_0000;
        1: key_pool[0] = 32'hFFFF_FFFF;
        2: key_pool[0] = 32'h8000_0000;
        3: key_pool[0] = 32'h7FFF_FFFF;
        default: ;
      endcase
      for (n = 0; n < PHASE_LEN; n++) begin
        key = ($urandom_range(0, 9) == 0) ? 32'($urandom) :
                                            key_pool[$urandom_range(0, pool_n - 1)];
        send_req(($urandom_range(0, 1) == 1) ? lrukv_pkg::MODE_PUT : lrukv_pkg::MODE_GET,
                 key, 32'($urandom), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    mismatches += response_q.size();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
sv/lrukv_pkg.sv
sv/lrukv_if.sv
sv/lrukv_ctrl.sv
sv/lrukv_dp.sv
sv/lru_key_value_cache_unit.sv
tb/tb_lru_key_value_cache_unit.sv
